// ----- rtl/bad_pkg.sv -----
// ----------------------------------------------------------------------------
// Box average downsampler package
// Shared widths, register indexes, sequencer states, the structs that
// travel between the top level and the divider and the queued result.
// ----------------------------------------------------------------------------
package bad_pkg;

	// Fixed field and register widths.
	localparam int PIX_W        = 8;
	localparam int DIM_W        = 13;
	localparam int FACT_W       = 5;
	localparam int Y_W          = 12;
	localparam int CFG_IDX_W    = 2;
	localparam int HEIGHT_LIMIT = 4096;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FACTOR = 2'd2;

	// Register values after reset.
	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [FACT_W-1:0] RST_BLOCK_FACTOR = 5'd2;

	// Depth of the result queue in front of the output channel.
	localparam int OQ_DEPTH = 8;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

	// Geometry sequencer states.
	typedef enum logic [2:0] {
		RS_IDLE,
		RS_WIDTH,
		RS_HEIGHT,
		RS_COL,
		RS_ROW
	} rs_state_t;

	// Request to the shared divider.
	typedef struct packed {
		logic              start;
		logic [DIM_W-1:0]  dividend;
		logic [FACT_W-1:0] divisor;
	} div_req_t;

	// Answer from the shared divider.
	typedef struct packed {
		logic              done;
		logic [DIM_W-1:0]  quot;
		logic [FACT_W-1:0] rem;
	} div_rsp_t;

	// One queued result.
	typedef struct packed {
		logic [PIX_W-1:0] mean_value;
		logic             row_end;
		logic             image_end;
	} res_t;

endpackage

// ----- rtl/bad_pix_if.sv -----
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one grayscale pixel per transaction.
// ----------------------------------------------------------------------------
interface bad_pix_if import bad_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);

endinterface

// ----- rtl/bad_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one block mean and its end flags per
// transaction.
// ----------------------------------------------------------------------------
interface bad_res_if import bad_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] mean_value;
	logic             row_end;
	logic             image_end;

	modport source (output valid, output mean_value, output row_end, output image_end,
		input ready);
	modport sink   (input valid, input mean_value, input row_end, input image_end,
		output ready);

endinterface

// ----- rtl/bad_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. A read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module bad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/bad_div.sv -----
// ----------------------------------------------------------------------------
// Shared restoring divider
// Divides a 13-bit dividend by a 5-bit non-zero divisor, one quotient bit
// per cycle. The result is flagged by a one-cycle done pulse.
// ----------------------------------------------------------------------------
module bad_div import bad_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIM_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIM_W-1:0]  dvd_q;
	logic [FACT_W-1:0] rem_q;
	logic [FACT_W-1:0] dsr_q;
	logic [FACT_W:0]   trial;
	logic              qbit;
	logic [FACT_W:0]   trial_sub;

	// One restoring step: shift in the next dividend bit and try a subtraction.
	always_comb begin
		trial     = {rem_q, dvd_q[DIM_W-1]};
		qbit      = trial >= {1'b0, dsr_q};
		trial_sub = trial - {1'b0, dsr_q};
	end

	// Control: busy while the quotient bits are produced, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits as it shifts.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIM_W-2:0], qbit};
			rem_q <= qbit ? trial_sub[FACT_W-1:0] : trial[FACT_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- rtl/box_average_downsampler_top.sv -----
// ----------------------------------------------------------------------------
// Box average downsampler
// Averages every factor x factor block of a raster-order grayscale stream
// into one pixel, rounded half up. Row sums of each block are accumulated
// per output column in a block-sum RAM by read-modify-write.
// ----------------------------------------------------------------------------
//  Channel     Direction  Transaction             Payload
//  pixel_in    in         one input pixel         pixel_value
//  res_out     out        one block mean          mean_value, row_end, image_end
//  cfg_*       in         register write          cfg_index, cfg_data
//
//  One pixel per clock is accepted while the sequencer is idle and the
//  result queue has room; the block-sum RAM does one read and one write per
//  cycle, with forwarding between neighbours. After reset and after each
//  register write, the divider recomputes the output geometry and
//  position, and no pixel is accepted meanwhile. The result queue holds
//  eight entries; pixels also stall when it and the pipeline together
//  could not take another result.
// ----------------------------------------------------------------------------
module box_average_downsampler_top import bad_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_FACTOR = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bad_pix_if.sink              pixel_in,
	bad_res_if.source            res_out,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	// Derived widths.
	localparam int FMAX_CFG = (1 << FACT_W) - 1;
	localparam int FMAX     = (MAX_FACTOR < FMAX_CFG) ? MAX_FACTOR : FMAX_CFG;
	localparam int FW       = $clog2(FMAX + 1);
	localparam int XW       = $clog2(MAX_WIDTH);
	localparam int CW       = ((XW > DIM_W) ? XW : DIM_W) + 1;
	localparam int HW       = $clog2(255 * FMAX + 1);
	localparam int SW       = $clog2(255 * FMAX * FMAX + 1);
	localparam int NW       = $clog2(255 * FMAX * FMAX + (FMAX * FMAX) / 2 + 1);
	localparam int AW       = $clog2(FMAX * FMAX + 1);
	localparam int K        = NW + AW;
	localparam int RW       = K + 1;
	localparam int PW       = NW + RW;

	// Configuration registers.
	logic [DIM_W-1:0]  cfg_w_q;
	logic [DIM_W-1:0]  cfg_h_q;
	logic [FACT_W-1:0] cfg_f_q;

	// Clamped geometry.
	logic [DIM_W-1:0] w_cl;
	logic [DIM_W-1:0] h_cl;
	logic [FW-1:0]    f_cl;

	// Geometry from the divider.
	logic [DIM_W-1:0] out_w_q;
	logic [DIM_W-1:0] out_h_q;
	logic [RW-1:0]    recip_q;
	logic [AW-1:0]    half_q;

	// Stream position.
	logic [XW-1:0]  x_q;
	logic [Y_W-1:0] y_q;
	logic [FW-1:0]  in_x_q;
	logic [FW-1:0]  in_y_q;
	logic [XW-1:0]  bc_q;
	logic [Y_W-1:0] by_q;
	logic [HW-1:0]  hp_q;

	// Sequencer.
	rs_state_t state_q;
	rs_state_t state_d;
	logic      pend_q;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	// Reciprocal table for the block areas.
	logic [RW-1:0] recip_tab [FMAX+1];

	// Accept-side logic.
	logic          accept;
	logic          active;
	logic          col_done;
	logic          row_last;
	logic          rend;
	logic          iend;
	logic [HW-1:0] hp_d;
	logic [CW-1:0] x_inc;
	logic [CW-1:0] y_inc;
	logic          wrap_x;
	logic          wrap_y;
	logic          over_y;

	// Pipeline.
	logic          v_s1;
	logic          first_s1;
	logic          last_s1;
	logic [XW-1:0] addr_s1;
	logic [HW-1:0] hsum_s1;
	logic          rend_s1;
	logic          iend_s1;
	logic [SW-1:0] rd_data;
	logic [SW-1:0] old_s1;
	logic [SW-1:0] sum_s1;
	logic          fwd_v_q;
	logic [XW-1:0] fwd_addr_q;
	logic [SW-1:0] fwd_data_q;
	logic          v_s2;
	logic [NW-1:0] n_s2;
	logic          rend_s2;
	logic          iend_s2;
	logic          v_s3;
	logic [PW-1:0] prod_s3;
	logic          rend_s3;
	logic          iend_s3;

	// Result queue.
	res_t                oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_PTR_W:0]   oq_cnt_q;
	logic [OQ_PTR_W:0]   committed;
	logic                oq_pop;
	res_t                oq_head;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= RST_IMAGE_WIDTH;
			cfg_h_q <= RST_IMAGE_HEIGHT;
			cfg_f_q <= RST_BLOCK_FACTOR;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  cfg_w_q <= cfg_data;
				CFG_IMAGE_HEIGHT: cfg_h_q <= cfg_data;
				CFG_BLOCK_FACTOR: cfg_f_q <= cfg_data[FACT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers to their working ranges; zero counts as one.
	always_comb begin
		if (cfg_w_q == '0) begin
			w_cl = DIM_W'(1);
		end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
			w_cl = DIM_W'(MAX_WIDTH);
		end else begin
			w_cl = cfg_w_q;
		end
		if (cfg_h_q == '0) begin
			h_cl = DIM_W'(1);
		end else if (32'(cfg_h_q) > 32'(HEIGHT_LIMIT)) begin
			h_cl = DIM_W'(HEIGHT_LIMIT);
		end else begin
			h_cl = cfg_h_q;
		end
		if (cfg_f_q == '0) begin
			f_cl = FW'(1);
		end else if (32'(cfg_f_q) > 32'(FMAX)) begin
			f_cl = FW'(FMAX);
		end else begin
			f_cl = FW'(cfg_f_q);
		end
	end

	// Reciprocals of every possible block area, scaled by two to the K.
	assign recip_tab[0] = '0;
	for (genvar d = 1; d <= FMAX; d++) begin : g_recip
		localparam longint unsigned AREA = longint'(d) * longint'(d);
		localparam longint unsigned RV   = ((64'd1 << K) + AREA - 64'd1) / AREA;
		assign recip_tab[d] = RW'(RV);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state: width, height, column and row in turn.
	always_comb begin
		state_d = state_q;
		case (state_q)
			RS_IDLE:   if (pend_q) state_d = RS_WIDTH;
			RS_WIDTH:  if (div_rsp.done) state_d = RS_HEIGHT;
			RS_HEIGHT: if (div_rsp.done) state_d = RS_COL;
			RS_COL:    if (div_rsp.done) state_d = RS_ROW;
			RS_ROW:    if (div_rsp.done) state_d = RS_IDLE;
			default:   state_d = RS_IDLE;
		endcase
	end

	// Sequencer outputs: start a division on entry to each working state.
	always_comb begin
		div_req.start   = (state_d != state_q) && (state_d != RS_IDLE);
		div_req.divisor = FACT_W'(f_cl);
		case (state_d)
			RS_WIDTH:  div_req.dividend = w_cl;
			RS_HEIGHT: div_req.dividend = h_cl;
			RS_COL:    div_req.dividend = DIM_W'(x_q);
			RS_ROW:    div_req.dividend = DIM_W'(y_q);
			default:   div_req.dividend = '0;
		endcase
	end

	bad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// A register write leaves the geometry stale until the sequencer has run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
		end else if (cfg_wr_en) begin
			pend_q <= 1'b1;
		end else if (state_q == RS_IDLE && state_d == RS_WIDTH) begin
			pend_q <= 1'b0;
		end
	end

	// Factor-derived constants for the mean.
	always_ff @(posedge clk) begin
		if (state_q == RS_IDLE && state_d == RS_WIDTH) begin
			recip_q <= recip_tab[f_cl];
			half_q  <= AW'((2 * FW)'(f_cl) * (2 * FW)'(f_cl) >> 1);
		end
	end

	// Output geometry from the divider.
	always_ff @(posedge clk) begin
		if (div_rsp.done && state_q == RS_WIDTH) begin
			out_w_q <= div_rsp.quot;
		end
		if (div_rsp.done && state_q == RS_HEIGHT) begin
			out_h_q <= div_rsp.quot;
		end
	end

	// Credit check: the queue must have room for every result in flight.
	always_comb begin
		committed = oq_cnt_q
			+ (OQ_PTR_W + 1)'(v_s1 && last_s1)
			+ (OQ_PTR_W + 1)'(v_s2)
			+ (OQ_PTR_W + 1)'(v_s3);
	end

	assign pixel_in.ready = (state_q == RS_IDLE) && !pend_q
		&& (committed < (OQ_PTR_W + 1)'(OQ_DEPTH));
	assign accept = pixel_in.valid && pixel_in.ready;

	// Classify the incoming pixel against the current block position.
	always_comb begin
		active   = (CW'(bc_q) < CW'(out_w_q)) && (CW'(by_q) < CW'(out_h_q));
		col_done = in_x_q == f_cl - 1'b1;
		row_last = in_y_q == f_cl - 1'b1;
		rend     = CW'(bc_q) == CW'(out_w_q) - 1'b1;
		iend     = rend && (CW'(by_q) == CW'(out_h_q) - 1'b1);
		hp_d     = ((in_x_q == '0) ? '0 : hp_q) + HW'(pixel_in.pixel_value);
		x_inc    = CW'(x_q) + 1'b1;
		y_inc    = CW'(y_q) + 1'b1;
		wrap_x   = x_inc >= CW'(w_cl);
		wrap_y   = y_inc >= CW'(h_cl);
		over_y   = CW'(y_q) >= CW'(h_cl);
	end

	// Position counters: stepped by each pixel, reloaded by the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			in_x_q <= '0;
			in_y_q <= '0;
			bc_q   <= '0;
			by_q   <= '0;
			hp_q   <= '0;
		end else if (div_rsp.done && state_q == RS_COL) begin
			bc_q   <= XW'(div_rsp.quot);
			in_x_q <= FW'(div_rsp.rem);
		end else if (div_rsp.done && state_q == RS_ROW) begin
			by_q   <= Y_W'(div_rsp.quot);
			in_y_q <= FW'(div_rsp.rem);
		end else if (accept) begin
			if (active) begin
				hp_q <= hp_d;
			end
			if (wrap_x) begin
				x_q    <= '0;
				in_x_q <= '0;
				bc_q   <= '0;
				if (wrap_y) begin
					y_q    <= '0;
					in_y_q <= '0;
					by_q   <= '0;
				end else begin
					y_q <= Y_W'(y_inc);
					if (row_last) begin
						in_y_q <= '0;
						by_q   <= by_q + 1'b1;
					end else begin
						in_y_q <= in_y_q + 1'b1;
					end
				end
			end else begin
				x_q <= XW'(x_inc);
				if (col_done) begin
					in_x_q <= '0;
					bc_q   <= bc_q + 1'b1;
				end else begin
					in_x_q <= in_x_q + 1'b1;
				end
				if (over_y) begin
					y_q    <= '0;
					in_y_q <= '0;
					by_q   <= '0;
				end
			end
		end
	end

	// Stage 1 entry: a pixel that closes a block row issues a RAM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && active && col_done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= in_y_q == '0;
			last_s1  <= row_last;
			addr_s1  <= bc_q;
			hsum_s1  <= hp_d;
			rend_s1  <= rend;
			iend_s1  <= iend;
		end
	end

	bad_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_WIDTH)
	) u_sums (
		.clk     (clk),
		.wr_en   (v_s1),
		.wr_addr (addr_s1),
		.wr_data (sum_s1),
		.rd_en   (accept),
		.rd_addr (bc_q),
		.rd_data (rd_data)
	);

	// Stage 1: accumulate the row sum, forwarding a write from the cycle before.
	always_comb begin
		old_s1 = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;
		sum_s1 = first_s1 ? SW'(hsum_s1) : old_s1 + SW'(hsum_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= sum_s1;
	end

	// Stage 2: rounding offset on completed blocks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && last_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		n_s2    <= NW'(sum_s1) + NW'(half_q);
		rend_s2 <= rend_s1;
		iend_s2 <= iend_s1;
	end

	// Stage 3: multiply by the area reciprocal; the mean is the top bits.
	always_ff @(posedge clk) begin
		prod_s3 <= PW'(n_s2) * PW'(recip_q);
		rend_s3 <= rend_s2;
		iend_s3 <= iend_s2;
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			oq_q[oq_wr_q] <= '{mean_value: prod_s3[K +: PIX_W], row_end: rend_s3,
				image_end: iend_s3};
		end
	end

	// Result queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (v_s3) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + (OQ_PTR_W + 1)'(v_s3) - (OQ_PTR_W + 1)'(oq_pop);
		end
	end

	// Output channel.
	assign oq_head           = oq_q[oq_rd_q];
	assign oq_pop            = res_out.valid && res_out.ready;
	assign res_out.valid     = oq_cnt_q != '0;
	assign res_out.mean_value = oq_head.mean_value;
	assign res_out.row_end   = oq_head.row_end;
	assign res_out.image_end = oq_head.image_end;

endmodule

// ----- sim/box_average_downsampler_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box average downsampler testbench
// Streams grayscale frames of many geometries through the block and checks
// every block mean and its end flags against a cycle-free predictor of the
// block-averaging arithmetic. Both channels stall at random, and geometry is
// changed between frames and, for width and height, part way through a frame.
// ----------------------------------------------------------------------------
module box_average_downsampler_top_tb;
	import bad_pkg::*;

	localparam int MAX_W       = 4096;
	localparam int MAX_F       = 16;
	localparam int RAND_ITEMS  = 1200;
	localparam int CALM_ITEMS  = 150;
	localparam int SETTLE      = 16;
	localparam int QUIET_LIMIT = 3000;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	bad_pix_if pix_bus ();
	bad_res_if res_bus ();

	box_average_downsampler_top #(
		.MAX_WIDTH  (MAX_W),
		.MAX_FACTOR (MAX_F)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (pix_bus),
		.res_out   (res_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: register copies, raster position and running sums.
	logic [DIM_W-1:0]  cfg_width;
	logic [DIM_W-1:0]  cfg_height;
	logic [FACT_W-1:0] cfg_factor;
	int unsigned       pos_col;
	int unsigned       pos_row;
	int unsigned       row_run_sum;
	int unsigned       block_col_sum [0:MAX_W-1];

	logic [PIX_W-1:0] pixel_backlog [$];
	res_t             block_means_due [$];

	bit          idle_on;
	bit          pixel_taken;
	int unsigned pix_gap;
	int unsigned res_gap;
	int unsigned pixels_queued;
	int unsigned errors_seen;
	int unsigned quiet_cycles;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Zero is taken as one and anything above the limit as the limit.
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// Advances the predictor by one accepted pixel and queues the block mean
	// that it completes, if any.
	task automatic absorb_pixel(input logic [PIX_W-1:0] pix);
		int unsigned w, h, f, out_w, out_h, in_x, in_y, col_blk, sum, area;
		res_t        mean;
		w     = clamp_dim(cfg_width, MAX_W);
		h     = clamp_dim(cfg_height, HEIGHT_LIMIT);
		f     = clamp_dim(cfg_factor, MAX_F);
		out_w = w / f;
		out_h = h / f;
		if (pos_col < out_w * f && pos_row < out_h * f) begin
			in_x        = pos_col % f;
			in_y        = pos_row % f;
			col_blk     = pos_col / f;
			row_run_sum = ((in_x == 0) ? 0 : row_run_sum) + pix;
			if (in_x == f - 1) begin
				sum = ((in_y == 0) ? 0 : block_col_sum[col_blk]) + row_run_sum;
				if (in_y == f - 1) begin
					area            = f * f;
					mean.mean_value = PIX_W'((sum + area / 2) / area);
					mean.row_end    = (col_blk == out_w - 1);
					mean.image_end  = mean.row_end && (pos_row / f == out_h - 1);
					block_means_due.push_back(mean);
				end
				block_col_sum[col_blk] = sum;
			end
		end
		// Step the raster position; a row beyond the height wraps to the top.
		pos_col++;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= h)
				pos_row = 0;
		end else if (pos_row >= h) begin
			pos_row = 0;
		end
	endtask

	// Monitor: accepted pixels feed the predictor, accepted means are checked.
	always @(posedge clk) begin
		res_t due;
		bit   busy;
		busy = cfg_wr_en;
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			absorb_pixel(pix_bus.pixel_value);
			pixel_taken = 1'b1;
			busy        = 1'b1;
		end
		if (arst_n && res_bus.valid && res_bus.ready) begin
			busy = 1'b1;
			if (block_means_due.size() == 0) begin
				$error("mean_value %0d arrived with no block pending", res_bus.mean_value);
				errors_seen++;
			end else begin
				due = block_means_due.pop_front();
				if (res_bus.mean_value !== due.mean_value) begin
					$error("mean_value: expected %0d, got %0d", due.mean_value,
						res_bus.mean_value);
					errors_seen++;
				end
				if (res_bus.row_end !== due.row_end) begin
					$error("row_end: expected %0d, got %0d", due.row_end, res_bus.row_end);
					errors_seen++;
				end
				if (res_bus.image_end !== due.image_end) begin
					$error("image_end: expected %0d, got %0d", due.image_end,
						res_bus.image_end);
					errors_seen++;
				end
			end
		end
		// Watchdog on cycles with no transaction and no register write.
		quiet_cycles = busy ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Pixel driver: holds each transaction until taken, with random gaps.
	always @(negedge clk) begin
		if (pixel_taken || !pix_bus.valid) begin
			pixel_taken = 1'b0;
			if (pix_gap > 0) begin
				pix_gap--;
				pix_bus.valid <= 1'b0;
			end else if (pixel_backlog.size() != 0) begin
				if (idle_on && $urandom_range(0, 11) == 0) begin
					pix_gap = $urandom_range(0, 7);
					pix_bus.valid <= 1'b0;
				end else begin
					pix_bus.valid       <= 1'b1;
					pix_bus.pixel_value <= pixel_backlog.pop_front();
				end
			end else begin
				pix_bus.valid <= 1'b0;
			end
		end
	end

	// Result back-pressure in random bursts.
	always @(negedge clk) begin
		if (res_gap > 0) begin
			res_gap--;
			res_bus.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			res_gap = $urandom_range(0, 7);
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= 1'b1;
		end
	end

	task automatic queue_pixel(input logic [PIX_W-1:0] v);
		pixel_backlog.push_back(v);
		pixels_queued++;
	endtask

	// Random pixels, with black and white turning up more often than chance.
	task automatic send_random(input int unsigned n);
		int unsigned pick;
		repeat (n) begin
			pick = $urandom_range(0, 15);
			queue_pixel((pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : PIX_W'($urandom_range(0, 255)));
		end
	endtask

	// Waits until every pixel is taken and every mean has come out, then lets
	// the pipeline settle for pixels that produce nothing.
	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || pix_bus.valid || block_means_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Feeds pixels until the raster position is back at the top-left corner.
	task automatic finish_frame();
		int unsigned w, h;
		w = clamp_dim(cfg_width, MAX_W);
		h = clamp_dim(cfg_height, HEIGHT_LIMIT);
		while (pos_col != 0 || pos_row != 0) begin
			if (pos_row >= h || pos_col >= w)
				send_random(1);
			else
				send_random((h - pos_row) * w - pos_col);
			wait_idle();
		end
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_IMAGE_WIDTH: begin
				cfg_width = val;
			end
			CFG_IMAGE_HEIGHT: begin
				cfg_height = val;
			end
			CFG_BLOCK_FACTOR: begin
				cfg_factor = val[FACT_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Writes the whole geometry once the block is idle. Unless the position is
	// to be kept, the current frame is completed first.
	task automatic write_regs(input int unsigned w, input int unsigned h, input int unsigned f,
		input bit keep_pos, input bit poke_spare);
		if (!keep_pos)
			finish_frame();
		wait_idle();
		put_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
		put_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
		put_reg(CFG_BLOCK_FACTOR, DIM_W'(f));
		if (poke_spare)
			put_reg(CFG_SPARE, DIM_W'($urandom));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stimulus.
	initial begin
		logic [PIX_W-1:0] quad [16] = '{8'd255, 8'd255, 8'd0, 8'd0,
			8'd255, 8'd255, 8'd0, 8'd0,
			8'd1, 8'd1, 8'd1, 8'd0,
			8'd0, 8'd0, 8'd0, 8'd0};
		int unsigned w, h, f, w2, area_px, stop_at, pick;

		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = CFG_IMAGE_WIDTH;
		cfg_data            = '0;
		pix_bus.valid       = 1'b0;
		pix_bus.pixel_value = '0;
		res_bus.ready       = 1'b0;
		cfg_width           = RST_IMAGE_WIDTH;
		cfg_height          = RST_IMAGE_HEIGHT;
		cfg_factor          = RST_BLOCK_FACTOR;
		pos_col             = 0;
		pos_row             = 0;
		row_run_sum         = 0;
		idle_on             = 1'b1;
		pixel_taken         = 1'b0;
		pix_gap             = 0;
		res_gap             = 0;
		pixels_queued       = 0;
		errors_seen         = 0;
		quiet_cycles        = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 4x4 image in 2x2 blocks: full white, full black, a sum of two that
		// rounds up and a sum of one that rounds down.
		write_regs(4, 4, 2, 1'b0, 1'b1);
		foreach (quad[i])
			queue_pixel(quad[i]);

		// Zero width, height and factor all act as one: every pixel ends an image.
		write_regs(0, 0, 0, 1'b0, 1'b0);
		queue_pixel(8'hAA);
		queue_pixel(8'h55);

		// Oversized factor saturates and still exceeds the image: no output.
		write_regs(3, 2, 31, 1'b0, 1'b0);
		send_random(6);

		// Saturated width across one row, then saturated height down one column.
		write_regs(8191, 0, 1, 1'b0, 1'b0);
		send_random(MAX_W);
		write_regs(1, 8191, 1, 1'b0, 1'b0);
		send_random(HEIGHT_LIMIT);

		// Largest block, all white: the largest possible sum.
		write_regs(16, 16, 16, 1'b0, 1'b0);
		repeat (256) queue_pixel(8'd255);

		// Random frames, with some width and height changes inside a frame.
		stop_at = pixels_queued + RAND_ITEMS;
		while (pixels_queued < stop_at) begin
			if ($urandom_range(0, 9) < 7) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					f = 0;
				else if (pick == 1)
					f = $urandom_range(17, 31);
				else if (pick < 4)
					f = $urandom_range(5, 16);
				else
					f = $urandom_range(1, 4);
				w = $urandom_range(0, 20);
				h = $urandom_range(0, 12);
				write_regs(w, h, f, 1'b0, $urandom_range(0, 7) == 0);
				repeat ($urandom_range(1, 2))
					send_random(clamp_dim(w, MAX_W) * clamp_dim(h, HEIGHT_LIMIT));
			end else begin
				// A whole frame first, so that every column sum a narrower
				// width can reach holds a value from this factor.
				w       = $urandom_range(2, 12);
				h       = $urandom_range(2, 12);
				f       = $urandom_range(1, 4);
				area_px = w * h;
				write_regs(w, h, f, 1'b0, 1'b0);
				send_random(area_px);
				send_random($urandom_range(1, area_px - 1));
				w2 = $urandom_range(0, w);
				write_regs(w2, h, f, 1'b1, 1'b0);
				send_random($urandom_range(1, 2 * area_px));
				write_regs(w2, $urandom_range(0, h), f, 1'b1, 1'b0);
				send_random($urandom_range(1, 2 * area_px));
			end
			if (pixels_queued + CALM_ITEMS >= stop_at)
				idle_on = 1'b0;
		end

		wait_idle();
		if (block_means_due.size() != 0) begin
			$error("%0d block means never arrived", block_means_due.size());
			errors_seen++;
		end
		if (errors_seen == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
